// ===== design/aarp_pkg.sv =====
// Shared types, codes and constants of the AARP address probe block.
package aarp_pkg;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int ACT_W  = 3;
  localparam int NET_W  = 16;
  localparam int NODE_W = 8;
  localparam int CNT_W  = 8;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Event codes
  localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RX_REQ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RX_RESP = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RX_PRB  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PROBE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RESP  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ACQ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FAIL  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REJ   = 3'd5;

  // Acquisition phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TENT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // Register indexes (word address)
  localparam logic [2:0] REG_CABLE_START = 3'd0;
  localparam logic [2:0] REG_CABLE_END   = 3'd1;
  localparam logic [2:0] REG_NET_BASE    = 3'd2;
  localparam logic [2:0] REG_MAX_PROBES  = 3'd3;
  localparam logic [2:0] REG_MAX_NODES   = 3'd4;
  localparam logic [2:0] REG_MAX_NETS    = 3'd5;

  // Register reset values
  localparam logic [NET_W-1:0] NET_BASE_RST   = 16'hff00;
  localparam logic [CNT_W-1:0] MAX_PROBES_RST = 8'd10;
  localparam logic [CNT_W-1:0] MAX_NODES_RST  = 8'd253;
  localparam logic [CNT_W-1:0] MAX_NETS_RST   = 8'd10;

  // Node number limits
  localparam logic [NODE_W-1:0] NODE_TOP = 8'hfd;
  localparam logic [NODE_W-1:0] NODE_BAD = 8'hff;

endpackage

// ===== design/aarp_in_if.sv =====
// Event channel: valid/ready handshake with the event fields.
interface aarp_in_if import aarp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [NET_W-1:0]  peer_net;
  logic [NODE_W-1:0] peer_node;
  logic [NET_W-1:0]  start_net;
  logic [NODE_W-1:0] start_node;
  logic [NET_W-1:0]  rand_word;
  logic [NODE_W-1:0] rand_byte;

  modport source (
    output valid, cmd, peer_net, peer_node, start_net, start_node, rand_word, rand_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, peer_net, peer_node, start_net, start_node, rand_word, rand_byte,
    output ready
  );
endinterface

// ===== design/aarp_out_if.sv =====
// Result channel: valid/ready handshake with action and address.
interface aarp_out_if import aarp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [NET_W-1:0]  addr_net;
  logic [NODE_W-1:0] addr_node;

  modport source (
    output valid, action, addr_net, addr_node,
    input  ready
  );
  modport sink (
    input  valid, action, addr_net, addr_node,
    output ready
  );
endinterface

// ===== design/aarp_address_probe_fsm.sv =====
// AARP dynamic node address acquisition machine with APB register port.
//
// Takes one event per transfer (start, rx request, rx response, rx probe,
// probe timer tick) and returns exactly one action transfer for it. The
// action passes the execute and result states to the output register, and
// the next event can follow once the block is back in idle. Drawing a new
// network from a random low byte (cable range unknown) adds the network pick
// state. Drawing one from a known cable range adds the remainder state before
// the network pick: that draw reduces the 16-bit random word modulo the range
// width with a single restoring remainder unit that settles one bit per cycle
// over the 16 bits of the word. The input is not ready while an event is in
// work; a finished result waits in the output register and the next event is
// accepted meanwhile, but its own result holds until the output register is
// free. Registers sit at byte address 4*index; the user must write them only
// while the block is idle, which the block itself does not enforce.
module aarp_address_probe_fsm import aarp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  aarp_in_if.sink           in_ch,
  aarp_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIV  = 5'b00100,
    S_NET  = 5'b01000,
    S_RES  = 5'b10000
  } state_t;

  // Configuration registers
  logic [NET_W-1:0] cable_start;
  logic [NET_W-1:0] cable_end;
  logic [NET_W-1:0] net_base;
  logic [CNT_W-1:0] max_probes;
  logic [CNT_W-1:0] max_nodes;
  logic [CNT_W-1:0] max_nets;

  // Machine state
  state_t            state;
  logic [1:0]        phase;
  logic [NET_W-1:0]  cand_net;
  logic [NODE_W-1:0] cand_node;
  logic [NET_W-1:0]  own_net;
  logic [NODE_W-1:0] own_node;
  logic [CNT_W-1:0]  probe_count;
  logic [CNT_W-1:0]  nodes_tried;
  logic [CNT_W-1:0]  nets_tried;
  logic [ACT_W-1:0]  act;
  logic [NET_W-1:0]  prev_cand_net;
  logic              need_net;

  // Captured event
  logic [CMD_W-1:0]  ev_cmd;
  logic [NET_W-1:0]  ev_peer_net;
  logic [NODE_W-1:0] ev_peer_node;
  logic [NET_W-1:0]  ev_start_net;
  logic [NODE_W-1:0] ev_start_node;
  logic [NET_W-1:0]  ev_rand_word;
  logic [NODE_W-1:0] ev_rand_byte;

  // Remainder unit
  logic [NET_W:0]   div_rem;
  logic [NET_W-1:0] div_dvd;
  logic [3:0]       div_cnt;
  logic [NET_W:0]   span;
  logic [NET_W:0]   div_trial;

  // Output register
  logic              out_valid;
  logic [ACT_W-1:0]  out_action;
  logic [NET_W-1:0]  out_net;
  logic [NODE_W-1:0] out_node;

  // Event step results
  logic [1:0]        phase_next;
  logic [NET_W-1:0]  cand_net_next;
  logic [NODE_W-1:0] cand_node_next;
  logic [NET_W-1:0]  own_net_next;
  logic [NODE_W-1:0] own_node_next;
  logic [CNT_W-1:0]  probe_count_next;
  logic [CNT_W-1:0]  nodes_tried_next;
  logic [CNT_W-1:0]  nets_tried_next;
  logic [ACT_W-1:0]  act_next;
  logic [NET_W-1:0]  prev_cand_net_next;
  logic              need_net_next;

  logic              in_xfer;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;
  logic              out_free;
  logic [NET_W-1:0]  net_known;
  logic [NET_W-1:0]  net_unknown;
  logic [NODE_W-1:0] low_pick;

  // Random node 1..253 from one byte; rand < 2*253 so one subtract suffices
  function automatic logic [NODE_W-1:0] pick_node(input logic [NODE_W-1:0] r);
    logic [NODE_W-1:0] m;
    m = (r >= NODE_TOP) ? (r - NODE_TOP) : r;
    return m + 8'd1;
  endfunction

  // Step node, wrap the top node back to one
  function automatic logic [NODE_W-1:0] next_node(input logic [NODE_W-1:0] n);
    return (n == NODE_TOP) ? 8'd1 : (n + 8'd1);
  endfunction

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];
  assign pready    = 1'b1;
  assign out_free  = !out_valid || out_ch.ready;

  assign out_ch.valid     = out_valid;
  assign out_ch.action    = out_action;
  assign out_ch.addr_net  = out_net;
  assign out_ch.addr_node = out_node;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      cable_start <= '0;
      cable_end   <= '0;
      net_base    <= NET_BASE_RST;
      max_probes  <= MAX_PROBES_RST;
      max_nodes   <= MAX_NODES_RST;
      max_nets    <= MAX_NETS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CABLE_START: cable_start <= pwdata[NET_W-1:0];
        REG_CABLE_END:   cable_end   <= pwdata[NET_W-1:0];
        REG_NET_BASE:    net_base    <= pwdata[NET_W-1:0];
        REG_MAX_PROBES:  max_probes  <= pwdata[CNT_W-1:0];
        REG_MAX_NODES:   max_nodes   <= pwdata[CNT_W-1:0];
        REG_MAX_NETS:    max_nets    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (cfg_idx)
      REG_CABLE_START: prdata = {16'd0, cable_start};
      REG_CABLE_END:   prdata = {16'd0, cable_end};
      REG_NET_BASE:    prdata = {16'd0, net_base};
      REG_MAX_PROBES:  prdata = {24'd0, max_probes};
      REG_MAX_NODES:   prdata = {24'd0, max_nodes};
      REG_MAX_NETS:    prdata = {24'd0, max_nets};
      default:         prdata = '0;
    endcase
  end

  // Work out one event against the current state
  always_comb begin
    logic is_cand;
    logic is_own;
    logic [CNT_W-1:0] nt;
    logic [CNT_W-1:0] nn;
    is_cand = (ev_peer_net == cand_net) && (ev_peer_node == cand_node);
    is_own  = (ev_peer_net == own_net) && (ev_peer_node == own_node);
    nt = nodes_tried + 8'd1;
    nn = nets_tried + 8'd1;

    phase_next         = phase;
    cand_net_next      = cand_net;
    cand_node_next     = cand_node;
    own_net_next       = own_net;
    own_node_next      = own_node;
    probe_count_next   = probe_count;
    nodes_tried_next   = nodes_tried;
    nets_tried_next    = nets_tried;
    act_next           = ACT_NONE;
    prev_cand_net_next = cand_net;
    need_net_next      = 1'b0;

    case (ev_cmd)
      CMD_START: begin
        own_net_next  = '0;
        own_node_next = '0;
        if (phase == PH_TENT) begin
          act_next = ACT_REJ;
        end else begin
          cand_net_next      = ev_start_net;
          cand_node_next     = ev_start_node;
          prev_cand_net_next = ev_start_net;
          if (ev_start_net == '0 && ev_start_node == '0) begin
            cand_node_next = pick_node(ev_rand_byte);
            need_net_next  = 1'b1;
          end
          nodes_tried_next = '0;
          nets_tried_next  = '0;
          probe_count_next = 8'd1;
          phase_next       = PH_TENT;
          act_next         = ACT_PROBE;
        end
      end
      CMD_RX_REQ: begin
        if (phase == PH_DONE && is_own) act_next = ACT_RESP;
      end
      CMD_RX_RESP, CMD_RX_PRB: begin
        if (phase == PH_TENT && is_cand) begin
          cand_node_next   = next_node(cand_node);
          nodes_tried_next = nt;
          nets_tried_next  = nets_tried;
          if (nt == max_nodes) begin
            need_net_next    = 1'b1;
            cand_node_next   = pick_node(ev_rand_byte);
            nodes_tried_next = '0;
            nets_tried_next  = nn;
          end
          if (nets_tried_next == max_nets) begin
            probe_count_next = '0;
            phase_next       = PH_IDLE;
            act_next         = ACT_FAIL;
          end else begin
            probe_count_next = 8'd1;
            phase_next       = PH_TENT;
            act_next         = ACT_PROBE;
          end
        end else if (ev_cmd == CMD_RX_PRB && phase == PH_DONE && is_own) begin
          act_next = ACT_RESP;
        end
      end
      CMD_TICK: begin
        if (phase == PH_TENT) begin
          if (probe_count != max_probes) begin
            probe_count_next = probe_count + 8'd1;
            act_next         = ACT_PROBE;
          end else begin
            own_net_next  = cand_net;
            own_node_next = cand_node;
            phase_next    = PH_DONE;
            act_next      = ACT_ACQ;
          end
        end
      end
      default: ;
    endcase
  end

  // Network pick from remainder (known range) or random low byte
  assign span      = {1'b0, cable_end - cable_start} + 17'd1;
  assign div_trial = {div_rem[NET_W-1:0], div_dvd[NET_W-1]};

  always_comb begin
    logic [NET_W-1:0] n;
    n = cable_start + div_rem[NET_W-1:0];
    if (n == prev_cand_net) n = (n == cable_end) ? cable_start : (n + 16'd1);
    net_known = n;
  end

  always_comb begin
    low_pick = ev_rand_word[7:0];
    if (low_pick == prev_cand_net[7:0]) low_pick = low_pick + 8'd1;
    if (low_pick == NODE_BAD) low_pick = '0;
    net_unknown = net_base | {8'd0, low_pick};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_IDLE;
      cand_net    <= '0;
      cand_node   <= '0;
      own_net     <= '0;
      own_node    <= '0;
      probe_count <= '0;
      nodes_tried <= '0;
      nets_tried  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_RES) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer) state <= S_EXEC;
        end
        S_EXEC: begin
          phase       <= phase_next;
          cand_net    <= cand_net_next;
          cand_node   <= cand_node_next;
          own_net     <= own_net_next;
          own_node    <= own_node_next;
          probe_count <= probe_count_next;
          nodes_tried <= nodes_tried_next;
          nets_tried  <= nets_tried_next;
          if (!need_net_next) state <= S_RES;
          else if (cable_start != '0) state <= S_DIV;
          else state <= S_NET;
        end
        S_DIV: begin
          if (div_cnt == '0) state <= S_NET;
        end
        S_NET: begin
          cand_net <= (cable_start != '0) ? net_known : net_unknown;
          state    <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Event capture, remainder unit and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_cmd        <= in_ch.cmd;
      ev_peer_net   <= in_ch.peer_net;
      ev_peer_node  <= in_ch.peer_node;
      ev_start_net  <= in_ch.start_net;
      ev_start_node <= in_ch.start_node;
      ev_rand_word  <= in_ch.rand_word;
      ev_rand_byte  <= in_ch.rand_byte;
    end
    if (state == S_EXEC) begin
      act           <= act_next;
      prev_cand_net <= prev_cand_net_next;
      need_net      <= need_net_next;
      div_rem       <= '0;
      div_dvd       <= ev_rand_word;
      div_cnt       <= 4'd15;
    end
    // One remainder bit per cycle
    if (state == S_DIV) begin
      div_rem <= (div_trial >= span) ? (div_trial - span) : div_trial;
      div_dvd <= {div_dvd[NET_W-2:0], 1'b0};
      div_cnt <= div_cnt - 4'd1;
    end
    if (state == S_RES && out_free) begin
      out_action <= act;
      case (act)
        ACT_PROBE: begin
          out_net  <= cand_net;
          out_node <= cand_node;
        end
        ACT_RESP, ACT_ACQ: begin
          out_net  <= own_net;
          out_node <= own_node;
        end
        default: begin
          out_net  <= '0;
          out_node <= '0;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_EXEC)
    else $error("accepted event did not enter execution");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == 4'd0) |=> state == S_NET)
    else $error("remainder unit did not hand over to network pick");

  a_net_pick_path: assert property (@(posedge clk) disable iff (rst)
    state == S_NET |-> need_net)
    else $error("network pick without a pending draw");

  a_fail_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES && act == ACT_FAIL) |-> phase == PH_IDLE)
    else $error("failure reported while still probing");

  a_acq_own: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES && act == ACT_ACQ) |->
      (phase == PH_DONE && own_net == cand_net && own_node == cand_node))
    else $error("acquired address differs from candidate");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the AARP dynamic address probe machine.
`timescale 1ns / 1ps

module testbench;
  import aarp_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT   = 4000;

  // Event codes the block does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NET_W-1:0]  peer_net;
    logic [NODE_W-1:0] peer_node;
    logic [NET_W-1:0]  start_net;
    logic [NODE_W-1:0] start_node;
    logic [NET_W-1:0]  rand_word;
    logic [NODE_W-1:0] rand_byte;
  } probe_event_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [NET_W-1:0]  addr_net;
    logic [NODE_W-1:0] addr_node;
  } probe_action_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  aarp_in_if  in_ch ();
  aarp_out_if out_ch ();

  aarp_address_probe_fsm u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Mirror of the block's registers
  logic [NET_W-1:0]  cfg_cable_lo;
  logic [NET_W-1:0]  cfg_cable_hi;
  logic [NET_W-1:0]  cfg_net_base;
  logic [CNT_W-1:0]  cfg_probe_lim;
  logic [CNT_W-1:0]  cfg_node_lim;
  logic [CNT_W-1:0]  cfg_net_lim;

  // Mirror of the acquisition state
  logic [1:0]        acq_phase;
  logic [NET_W-1:0]  try_net;
  logic [NODE_W-1:0] try_node;
  logic [NET_W-1:0]  my_net;
  logic [NODE_W-1:0] my_node;
  logic [CNT_W-1:0]  probes_sent;
  logic [CNT_W-1:0]  node_fails;
  logic [CNT_W-1:0]  net_fails;

  probe_event_t  pending_events[$];
  probe_action_t due_actions[$];
  int unsigned   n_sent;
  int unsigned   n_taken;
  int unsigned   n_errors;
  int unsigned   n_random;
  int unsigned   send_gap_pct;
  int unsigned   recv_stall_pct;
  logic          in_done;

  function automatic void clear_model();
    cfg_cable_lo  = '0;
    cfg_cable_hi  = '0;
    cfg_net_base  = NET_BASE_RST;
    cfg_probe_lim = MAX_PROBES_RST;
    cfg_node_lim  = MAX_NODES_RST;
    cfg_net_lim   = MAX_NETS_RST;
    acq_phase     = PH_IDLE;
    try_net       = '0;
    try_node      = '0;
    my_net        = '0;
    my_node       = '0;
    probes_sent   = '0;
    node_fails    = '0;
    net_fails     = '0;
  endfunction

  function automatic void draw_node(logic [NODE_W-1:0] r);
    try_node = (r % NODE_TOP) + 8'd1;
  endfunction

  function automatic void advance_node();
    try_node = (try_node == NODE_TOP) ? 8'd1 : try_node + 8'd1;
  endfunction

  // Pick a fresh network, stepping once past a draw that hits the one just tried
  function automatic void draw_net(logic [NET_W-1:0] r);
    logic [NET_W-1:0]  diff;
    logic [NODE_W-1:0] low;
    int unsigned       span;
    int unsigned       n;
    if (cfg_cable_lo != '0) begin
      diff = cfg_cable_hi - cfg_cable_lo;
      span = {16'h0000, diff} + 32'd1;
      n = ({16'h0000, cfg_cable_lo} + ({16'h0000, r} % span)) & 32'h0000ffff;
      if (n[NET_W-1:0] == try_net)
        n = (n[NET_W-1:0] == cfg_cable_hi) ? {16'h0000, cfg_cable_lo}
                                            : ((n + 32'd1) & 32'h0000ffff);
      try_net = n[NET_W-1:0];
    end else begin
      low = r[7:0];
      if (low == try_net[7:0])
        low = low + 8'd1;
      if (low == 8'hff)
        low = 8'h00;
      try_net = cfg_net_base | {8'h00, low};
    end
  endfunction

  function automatic logic [ACT_W-1:0] emit_probe();
    acq_phase   = PH_TENT;
    probes_sent = probes_sent + 8'd1;
    return ACT_PROBE;
  endfunction

  // Someone else holds the candidate: step the node, maybe the network
  function automatic logic [ACT_W-1:0] on_conflict(logic [NET_W-1:0] rw,
                                                   logic [NODE_W-1:0] rb);
    probes_sent = '0;
    advance_node();
    node_fails = node_fails + 8'd1;
    if (node_fails == cfg_node_lim) begin
      draw_net(rw);
      draw_node(rb);
      node_fails = '0;
      net_fails  = net_fails + 8'd1;
    end
    if (net_fails == cfg_net_lim) begin
      acq_phase = PH_IDLE;
      return ACT_FAIL;
    end
    return emit_probe();
  endfunction

  function automatic probe_action_t next_action(probe_event_t ev);
    probe_action_t res;
    logic          hit_try;
    logic          hit_mine;
    res.action = ACT_NONE;
    hit_try  = (ev.peer_net == try_net) && (ev.peer_node == try_node);
    hit_mine = (ev.peer_net == my_net) && (ev.peer_node == my_node);
    case (ev.cmd)
      CMD_START: begin
        my_net  = '0;
        my_node = '0;
        if (acq_phase == PH_TENT) begin
          res.action = ACT_REJ;
        end else begin
          acq_phase = PH_IDLE;
          try_net   = ev.start_net;
          try_node  = ev.start_node;
          if (ev.start_net == '0 && ev.start_node == '0) begin
            draw_node(ev.rand_byte);
            draw_net(ev.rand_word);
          end
          probes_sent = '0;
          node_fails  = '0;
          net_fails   = '0;
          res.action  = emit_probe();
        end
      end
      CMD_RX_REQ: begin
        if (acq_phase == PH_DONE && hit_mine)
          res.action = ACT_RESP;
      end
      CMD_RX_RESP: begin
        if (acq_phase == PH_TENT && hit_try)
          res.action = on_conflict(ev.rand_word, ev.rand_byte);
      end
      CMD_RX_PRB: begin
        if (acq_phase == PH_TENT && hit_try)
          res.action = on_conflict(ev.rand_word, ev.rand_byte);
        else if (acq_phase == PH_DONE && hit_mine)
          res.action = ACT_RESP;
      end
      CMD_TICK: begin
        if (acq_phase == PH_TENT) begin
          if (probes_sent != cfg_probe_lim) begin
            res.action = emit_probe();
          end else begin
            my_net     = try_net;
            my_node    = try_node;
            acq_phase  = PH_DONE;
            res.action = ACT_ACQ;
          end
        end
      end
      default: ;
    endcase
    case (res.action)
      ACT_PROBE: begin
        res.addr_net  = try_net;
        res.addr_node = try_node;
      end
      ACT_RESP, ACT_ACQ: begin
        res.addr_net  = my_net;
        res.addr_node = my_node;
      end
      default: begin
        res.addr_net  = '0;
        res.addr_node = '0;
      end
    endcase
    return res;
  endfunction

  // Event driver: hold valid until the transfer, gap only between events
  always @(negedge clk) begin : drive_events
    probe_event_t ev;
    if (!in_ch.valid || in_done) begin
      if (!rst && pending_events.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        ev = pending_events.pop_front();
        in_ch.cmd        <= ev.cmd;
        in_ch.peer_net   <= ev.peer_net;
        in_ch.peer_node  <= ev.peer_node;
        in_ch.start_net  <= ev.start_net;
        in_ch.start_node <= ev.start_node;
        in_ch.rand_word  <= ev.rand_word;
        in_ch.rand_byte  <= ev.rand_byte;
        in_ch.valid      <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each action transfer, predict on each event transfer
  always @(posedge clk) begin : check_actions
    probe_action_t want;
    probe_event_t  ev;
    if (rst) begin
      in_done <= 1'b0;
    end else begin
      in_done <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (due_actions.size() == 0) begin
          $error("unexpected action transfer: action %0d", out_ch.action);
          n_errors = n_errors + 1;
        end else begin
          want = due_actions.pop_front();
          if (out_ch.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, out_ch.action);
            n_errors = n_errors + 1;
          end
          if (out_ch.addr_net !== want.addr_net) begin
            $error("addr_net: expected %h, got %h", want.addr_net, out_ch.addr_net);
            n_errors = n_errors + 1;
          end
          if (out_ch.addr_node !== want.addr_node) begin
            $error("addr_node: expected %h, got %h", want.addr_node, out_ch.addr_node);
            n_errors = n_errors + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        ev.cmd        = in_ch.cmd;
        ev.peer_net   = in_ch.peer_net;
        ev.peer_node  = in_ch.peer_node;
        ev.start_net  = in_ch.start_net;
        ev.start_node = in_ch.start_node;
        ev.rand_word  = in_ch.rand_word;
        ev.rand_byte  = in_ch.rand_byte;
        due_actions.push_back(next_action(ev));
        n_taken <= n_taken + 1;
      end
    end
  end

  // Give up after too long without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
        quiet = 0;
      else
        quiet = quiet + 1;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [NET_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CABLE_START: cfg_cable_lo  = value;
      REG_CABLE_END:   cfg_cable_hi  = value;
      REG_NET_BASE:    cfg_net_base  = value;
      REG_MAX_PROBES:  cfg_probe_lim = value[7:0];
      REG_MAX_NODES:   cfg_node_lim  = value[7:0];
      REG_MAX_NETS:    cfg_net_lim   = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [NET_W-1:0] lo, input logic [NET_W-1:0] hi,
                               input logic [NET_W-1:0] base, input logic [CNT_W-1:0] probes,
                               input logic [CNT_W-1:0] nodes, input logic [CNT_W-1:0] nets);
    write_reg(REG_CABLE_START, lo);
    write_reg(REG_CABLE_END, hi);
    write_reg(REG_NET_BASE, base);
    write_reg(REG_MAX_PROBES, {8'h00, probes});
    write_reg(REG_MAX_NODES, {8'h00, nodes});
    write_reg(REG_MAX_NETS, {8'h00, nets});
  endtask

  // Queue one event and hold until it is taken, so the mirror is current
  task automatic issue(input logic [CMD_W-1:0] cmd,
                       input logic [NET_W-1:0] pnet, input logic [NODE_W-1:0] pnode,
                       input logic [NET_W-1:0] snet, input logic [NODE_W-1:0] snode,
                       input logic [NET_W-1:0] rw, input logic [NODE_W-1:0] rb);
    probe_event_t ev;
    ev.cmd        = cmd;
    ev.peer_net   = pnet;
    ev.peer_node  = pnode;
    ev.start_net  = snet;
    ev.start_node = snode;
    ev.rand_word  = rw;
    ev.rand_byte  = rb;
    pending_events.push_back(ev);
    n_sent = n_sent + 1;
    do @(posedge clk); while (n_taken != n_sent);
  endtask

  // Wait for every action, then let the block go quiet
  task automatic settle();
    while (due_actions.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed acquisition traffic, shaped by the current phase
  task automatic issue_random();
    probe_event_t ev;
    int unsigned  roll;
    int unsigned  tick_cut;
    int unsigned  hit_cut;
    int unsigned  start_cut;
    int unsigned  near_cut;
    if (n_random < 350) begin
      send_gap_pct   = 30;
      recv_stall_pct = 55;
    end else if (n_random < 700) begin
      send_gap_pct   = 55;
      recv_stall_pct = 30;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
    n_random = n_random + 1;

    ev.cmd        = 3'($urandom_range(CMD_UNUSED_LAST, CMD_START));
    ev.peer_net   = 16'($urandom);
    ev.peer_node  = 8'($urandom);
    ev.start_net  = 16'($urandom);
    ev.start_node = 8'($urandom);
    ev.rand_word  = 16'($urandom);
    ev.rand_byte  = 8'($urandom);
    // steer the network draw onto the one just tried
    if ($urandom_range(4) == 0) begin
      if (cfg_cable_lo != '0)
        ev.rand_word = try_net - cfg_cable_lo;
      else
        ev.rand_word[7:0] = try_net[7:0];
    end

    // long probe limits need calm periods to ever reach acquisition
    if (cfg_probe_lim > 8) begin
      tick_cut = 90; hit_cut = 93; start_cut = 95; near_cut = 98;
    end else begin
      tick_cut = 50; hit_cut = 70; start_cut = 78; near_cut = 88;
    end

    roll = $urandom_range(99);
    case (acq_phase)
      PH_TENT: begin
        if (roll < tick_cut) begin
          ev.cmd = CMD_TICK;
        end else if (roll < hit_cut) begin
          ev.cmd       = roll[0] ? CMD_RX_RESP : CMD_RX_PRB;
          ev.peer_net  = try_net;
          ev.peer_node = try_node;
        end else if (roll < start_cut) begin
          ev.cmd = CMD_START;
        end else if (roll < near_cut) begin
          ev.cmd       = roll[0] ? CMD_RX_RESP : CMD_RX_PRB;
          ev.peer_net  = try_net;
          ev.peer_node = try_node;
          if ($urandom_range(1))
            ev.peer_net = try_net ^ (16'h0001 << $urandom_range(15));
          else
            ev.peer_node = try_node ^ (8'h01 << $urandom_range(7));
        end
      end
      PH_DONE: begin
        if (roll < 35) begin
          ev.cmd       = CMD_RX_REQ;
          ev.peer_net  = my_net;
          ev.peer_node = my_node;
        end else if (roll < 50) begin
          ev.cmd       = CMD_RX_PRB;
          ev.peer_net  = my_net;
          ev.peer_node = my_node;
        end else if (roll < 65) begin
          ev.cmd = CMD_START;
        end else if (roll < 80) begin
          ev.peer_net  = my_net;
          ev.peer_node = my_node;
        end
      end
      default: begin
        if (roll < 70)
          ev.cmd = CMD_START;
      end
    endcase

    // preferred address or a random draw on start
    if (ev.cmd == CMD_START) begin
      case ($urandom_range(3))
        0, 1: begin
          ev.start_net  = '0;
          ev.start_node = '0;
        end
        2: ;
        default: begin
          if ($urandom_range(1))
            ev.start_net = '0;
          else
            ev.start_node = '0;
        end
      endcase
    end
    issue(ev.cmd, ev.peer_net, ev.peer_node, ev.start_net, ev.start_node,
          ev.rand_word, ev.rand_byte);
  endtask

  task automatic run_setting(input logic [NET_W-1:0] lo, input logic [NET_W-1:0] hi,
                             input logic [NET_W-1:0] base, input logic [CNT_W-1:0] probes,
                             input logic [CNT_W-1:0] nodes, input logic [CNT_W-1:0] nets,
                             input int unsigned count);
    apply_setting(lo, hi, base, probes, nodes, nets);
    repeat (count) issue_random();
    settle();
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0] code;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_TICK;
    in_ch.peer_net   = '0;
    in_ch.peer_node  = '0;
    in_ch.start_net  = '0;
    in_ch.start_node = '0;
    in_ch.rand_word  = '0;
    in_ch.rand_byte  = '0;
    out_ch.ready     = 1'b0;
    n_sent           = 0;
    n_taken          = 0;
    n_errors         = 0;
    n_random         = 0;
    send_gap_pct     = 30;
    recv_stall_pct   = 55;
    clear_model();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: short limits so every outcome shows up quickly
    apply_setting(16'h0000, 16'h0000, 16'hff00, 8'd2, 8'd1, 8'd2);
    issue(CMD_TICK, 16'hffff, 8'hff, 16'hffff, 8'hff, 16'hffff, 8'hff);
    issue(CMD_RX_REQ, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00);
    issue(CMD_RX_RESP, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00);
    issue(CMD_RX_PRB, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00);
    for (code = CMD_UNUSED_FIRST; code != CMD_START; code = code + 3'd1)
      issue(code, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00);
    // random pick from all-ones: low byte 0xff folds to zero
    issue(CMD_START, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'hffff, 8'hff);
    // start while tentative is rejected
    issue(CMD_START, 16'h0000, 8'h00, 16'hffff, 8'hff, 16'h0000, 8'h00);
    issue(CMD_RX_RESP, try_net, try_node + 8'd1, 16'h0000, 8'h00, 16'h0000, 8'h00);
    issue(CMD_TICK, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00);
    issue(CMD_TICK, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00);
    // answer for our address once held
    issue(CMD_RX_REQ, my_net, my_node, 16'h0000, 8'h00, 16'h0000, 8'h00);
    issue(CMD_RX_PRB, my_net, my_node, 16'h0000, 8'h00, 16'h0000, 8'h00);
    issue(CMD_RX_RESP, my_net, my_node, 16'h0000, 8'h00, 16'h0000, 8'h00);
    issue(CMD_RX_REQ, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00);
    issue(CMD_TICK, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00);
    // preferred all-ones address, then conflicts to failure
    issue(CMD_START, 16'h0000, 8'h00, 16'hffff, 8'hff, 16'h0000, 8'h00);
    issue(CMD_RX_PRB, try_net, try_node, 16'h0000, 8'h00, 16'h00ff, 8'h00);
    issue(CMD_RX_RESP, try_net, try_node, 16'h0000, 8'h00, 16'hff00, 8'hfd);
    // zero network with a nonzero node is still a preferred address
    issue(CMD_START, 16'h0000, 8'h00, 16'h0000, 8'h80, 16'h0000, 8'h00);
    issue(CMD_TICK, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00);
    issue(CMD_RX_PRB, try_net, try_node, 16'h0000, 8'h00, 16'h1234, 8'hfc);
    settle();

    // Random phases across range, base and limit settings
    run_setting(16'h0000, 16'h0000, 16'h0000, 8'd3, 8'd2, 8'd3, 125);
    run_setting(16'h0100, 16'h0103, 16'hffff, 8'd1, 8'd1, 8'd255, 125);
    run_setting(16'hfff0, 16'h000f, 16'h5a00, 8'd4, 8'd3, 8'd2, 125);
    run_setting(16'h0001, 16'hffff, 16'hff00, 8'd2, 8'd255, 8'd1, 125);
    run_setting(16'hffff, 16'hffff, 16'h0000, 8'd255, 8'd2, 8'd3, 300);
    run_setting(16'h8000, 16'h7fff, 16'h1200, 8'd1, 8'd1, 8'd4, 125);
    run_setting(16'h0000, 16'hffff, 16'hff00, 8'd10, 8'd253, 8'd10, 125);

    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
